@@ rtl/celog_pkg.sv @@
`timescale 1ns / 1ps

package celog_pkg;

   // Default sizes of the log ring and of the channel table.
   localparam int LOG_DEPTH_DEF = 16;
   localparam int CHANNELS_DEF  = 64;

   // Saturation limit of repeat and failure counters.
   localparam logic [15:0] REPEAT_MAX = 16'hFFFF;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_REPORT  = 2'd0,
      OP_READ    = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_SUMMARY = 2'd3
   } op_type;

   // Fields of one input item.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  channel;
      logic [7:0]  result_code;
      logic        direction_read;
      logic [7:0]  slave_id;
      logic [7:0]  function_code;
      logic [7:0]  datapoint_type;
      logic [15:0] register_address;
      logic [31:0] uptime_seconds;
      logic [7:0]  display_index;
   } req_item_type;

   // Fields of one result item.
   typedef struct packed {
      logic        status;
      logic [7:0]  sequence_res;
      logic [6:0]  entry_channel;
      logic [7:0]  entry_slave;
      logic [7:0]  error_code;
      logic [7:0]  entry_function;
      logic [7:0]  entry_datapoint;
      logic [15:0] entry_register;
      logic [15:0] repeats;
      logic [31:0] entry_uptime;
      logic        recovered;
      logic [6:0]  active_errors;
   } rsp_item_type;

   // One entry of the error log.
   typedef struct packed {
      logic [7:0]  seq;
      logic [6:0]  chan;
      logic [7:0]  slave;
      logic [7:0]  code;
      logic [7:0]  func;
      logic [7:0]  dpt;
      logic [15:0] regaddr;
      logic [15:0] reps;
      logic [31:0] uptime;
      logic        rec;
   } log_entry_type;

   // Status of the active error counter.
   typedef struct packed {
      logic       done;
      logic [6:0] count;
   } cnt_status_type;

endpackage

@@ rtl/celog_req_if.sv @@
`timescale 1ns / 1ps

interface celog_req_if import celog_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/celog_rsp_if.sv @@
`timescale 1ns / 1ps

interface celog_rsp_if import celog_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/channel_error_event_log_core.sv @@
`timescale 1ns / 1ps

// Channel error event log.
// Items enter on req_ch (valid/ready) and results leave on rsp_ch (valid/ready).
// csr_wr_en with csr_wr_data sets the number of visible channels.
// A report item gives no result. It is ignored when it is not a read or its
// channel is not visible or beyond CHANNELS; otherwise the previous result of the
// channel decides whether it logs, and the coalescing search reads one log entry
// per cycle from the log memory, newest first. Read, clear and summary items give a
// result; a summary waits for the error flag walk over min(visible, CHANNELS, 64).
// One item is worked on at a time; ready is high only while the core is idle.
// A finished result sits in an output register, so the next item is accepted
// while the receiver stalls; a second result waits until the first is taken.
// Reset empties the log, clears all counters, error flags and last results,
// and sets the visible channel count to zero. No clearing pass is needed.
module channel_error_event_log_core import celog_pkg::*; #(
   parameter int LOG_DEPTH = LOG_DEPTH_DEF,
   parameter int CHANNELS  = CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   celog_req_if.sink  req_ch,
   celog_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);

   localparam int AW       = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int FILL_W   = $clog2(LOG_DEPTH + 1);
   localparam int SW       = $clog2(2 * LOG_DEPTH);
   localparam int CH_DEPTH = (CHANNELS < 64) ? CHANNELS : 64;
   localparam int CW       = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EVAL = 6'b000010,
      ST_SRCH = 6'b000100,
      ST_LGRD = 6'b001000,
      ST_CNT  = 6'b010000,
      ST_RESP = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   req_item_type        req_ff, req_in;
   rsp_item_type        res_ff, res_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [6:0]          vis_ff;
   logic [AW-1:0]       head_ff, head_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [7:0]          seq_ff, seq_in;
   logic [15:0]         fails_ff, fails_in;
   logic [CH_DEPTH-1:0] err_ff, err_in;
   logic [CH_DEPTH-1:0] lvld_ff, lvld_in;
   logic [FILL_W-1:0]   rd_age_ff, rd_age_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [AW-1:0]       chk_slot_ff, chk_slot_in;
   logic                rec_ff, rec_in;

   // Log memory and channel result memory.
   log_entry_type       log_mem [LOG_DEPTH];
   log_entry_type       lg_rd_ff;
   logic                lg_re, lg_we;
   logic [AW-1:0]       lg_raddr, lg_waddr;
   log_entry_type       lg_wdata;
   logic [7:0]          ch_mem [CH_DEPTH];
   logic [7:0]          ch_rd_ff;
   logic                ch_re, ch_we;
   logic [CW-1:0]       ch_raddr;

   logic                cnt_start;
   logic [6:0]          cnt_limit;
   cnt_status_type      cnt_status;

   logic [CW-1:0]       cur_idx;
   logic [7:0]          last_code;
   logic [6:0]          cur_chan1;
   log_entry_type       new_entry;
   log_entry_type       hit_entry;
   logic                out_free;

   // Ring slot of an entry by age, newest is age zero.
   function automatic logic [AW-1:0] slot_of_age(input logic [AW-1:0] head,
                                                 input logic [FILL_W-1:0] age);
      logic [SW-1:0] t;
      t = SW'(head) + SW'(LOG_DEPTH - 1) - SW'(age);
      if (t >= SW'(LOG_DEPTH)) begin
         t = t - SW'(LOG_DEPTH);
      end
      return t[AW-1:0];
   endfunction

   assign cur_idx   = CW'(req_ff.channel);
   assign last_code = lvld_ff[cur_idx] ? ch_rd_ff : 8'd0;
   assign cur_chan1 = 7'(req_ff.channel) + 7'd1;
   assign cnt_limit = (32'(vis_ff) < CH_DEPTH) ? vis_ff : 7'(CH_DEPTH);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // Entry appended for the current event.
   always_comb begin
      new_entry.seq     = seq_ff + 8'd1;
      new_entry.chan    = cur_chan1;
      new_entry.slave   = req_ff.slave_id;
      new_entry.code    = req_ff.result_code;
      new_entry.func    = req_ff.function_code;
      new_entry.dpt     = req_ff.datapoint_type;
      new_entry.regaddr = req_ff.register_address;
      new_entry.reps    = 16'd1;
      new_entry.uptime  = req_ff.uptime_seconds;
      new_entry.rec     = rec_ff;
   end

   // Coalesced entry: one more repeat and a fresh uptime.
   always_comb begin
      hit_entry        = lg_rd_ff;
      hit_entry.uptime = req_ff.uptime_seconds;
      if (lg_rd_ff.reps != REPEAT_MAX) begin
         hit_entry.reps = lg_rd_ff.reps + 16'd1;
      end
   end

   // Main control sequence.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      head_in      = head_ff;
      fill_in      = fill_ff;
      seq_in       = seq_ff;
      fails_in     = fails_ff;
      err_in       = err_ff;
      lvld_in      = lvld_ff;
      rd_age_in    = rd_age_ff;
      chk_vld_in   = 1'b0;
      chk_slot_in  = chk_slot_ff;
      rec_in       = rec_ff;
      lg_re        = 1'b0;
      lg_raddr     = slot_of_age(head_ff, rd_age_ff);
      lg_we        = 1'b0;
      lg_waddr     = head_ff;
      lg_wdata     = new_entry;
      ch_re        = 1'b0;
      ch_we        = 1'b0;
      ch_raddr     = CW'(req_ch.data.channel);
      cnt_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               req_in = req_ch.data;
               res_in = '0;
               case (req_ch.data.opcode)
                  OP_REPORT: begin
                     if (req_ch.data.direction_read &&
                         (7'(req_ch.data.channel) < vis_ff) &&
                         (32'(req_ch.data.channel) < CHANNELS)) begin
                        ch_re    = 1'b1;
                        state_in = ST_EVAL;
                     end
                  end
                  OP_READ: begin
                     if (32'(req_ch.data.display_index) >= 32'(fill_ff)) begin
                        res_in.status = 1'b1;
                        state_in      = ST_RESP;
                     end else begin
                        lg_re    = 1'b1;
                        lg_raddr = slot_of_age(head_ff,
                                               FILL_W'(req_ch.data.display_index));
                        state_in = ST_LGRD;
                     end
                  end
                  OP_CLEAR: begin
                     head_in  = '0;
                     fill_in  = '0;
                     seq_in   = 8'd0;
                     fails_in = 16'd0;
                     state_in = ST_RESP;
                  end
                  OP_SUMMARY: begin
                     cnt_start = 1'b1;
                     state_in  = ST_CNT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Decide on the event from the previous result of the channel.
         ST_EVAL: begin
            state_in  = ST_IDLE;
            rd_age_in = '0;
            if (req_ff.result_code == last_code) begin
               if (req_ff.result_code != 8'd0) begin
                  rec_in   = 1'b0;
                  state_in = ST_SRCH;
               end
            end else begin
               ch_we            = 1'b1;
               lvld_in[cur_idx] = 1'b1;
               if (req_ff.result_code == 8'd0) begin
                  err_in[cur_idx] = 1'b0;
                  if (err_ff[cur_idx]) begin
                     rec_in   = 1'b1;
                     state_in = ST_SRCH;
                  end
               end else begin
                  err_in[cur_idx] = 1'b1;
                  rec_in          = 1'b0;
                  state_in        = ST_SRCH;
               end
            end
         end

         // Search newest to oldest; a read is issued while the last one is checked.
         ST_SRCH: begin
            if (chk_vld_ff && (lg_rd_ff.chan == cur_chan1)) begin
               state_in = ST_IDLE;
               if ((lg_rd_ff.code == req_ff.result_code) && (lg_rd_ff.rec == rec_ff)) begin
                  lg_we    = 1'b1;
                  lg_waddr = chk_slot_ff;
                  lg_wdata = hit_entry;
               end else begin
                  lg_we = 1'b1;
               end
            end else if (rd_age_ff < fill_ff) begin
               lg_re       = 1'b1;
               chk_vld_in  = 1'b1;
               chk_slot_in = slot_of_age(head_ff, rd_age_ff);
               rd_age_in   = rd_age_ff + FILL_W'(1);
            end else begin
               lg_we    = 1'b1;
               state_in = ST_IDLE;
            end
            // Bookkeeping for an appended entry.
            if (lg_we && (lg_waddr == head_ff) && (lg_wdata == new_entry)) begin
               head_in = (32'(head_ff) == LOG_DEPTH - 1) ? '0 : head_ff + AW'(1);
               if (32'(fill_ff) < LOG_DEPTH) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               seq_in = seq_ff + 8'd1;
               if (!rec_ff && (fails_ff != REPEAT_MAX)) begin
                  fails_in = fails_ff + 16'd1;
               end
            end
         end

         ST_LGRD: begin
            res_in.sequence_res    = lg_rd_ff.seq;
            res_in.entry_channel   = lg_rd_ff.chan;
            res_in.entry_slave     = lg_rd_ff.slave;
            res_in.error_code      = lg_rd_ff.code;
            res_in.entry_function  = lg_rd_ff.func;
            res_in.entry_datapoint = lg_rd_ff.dpt;
            res_in.entry_register  = lg_rd_ff.regaddr;
            res_in.repeats         = lg_rd_ff.reps;
            res_in.entry_uptime    = lg_rd_ff.uptime;
            res_in.recovered       = lg_rd_ff.rec;
            state_in               = ST_RESP;
         end

         ST_CNT: begin
            if (cnt_status.done) begin
               res_in.sequence_res  = (32'(fill_ff) > 255) ? 8'hFF : 8'(fill_ff);
               res_in.repeats       = fails_ff;
               res_in.active_errors = cnt_status.count;
               state_in             = ST_RESP;
            end
         end

         // Hand the result to the output register once it is free.
         ST_RESP: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vis_ff       <= 7'd0;
         head_ff      <= '0;
         fill_ff      <= '0;
         seq_ff       <= 8'd0;
         fails_ff     <= 16'd0;
         err_ff       <= '0;
         lvld_ff      <= '0;
         rd_age_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         rec_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            vis_ff <= csr_wr_data;
         end
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         seq_ff       <= seq_in;
         fails_ff     <= fails_in;
         err_ff       <= err_in;
         lvld_ff      <= lvld_in;
         rd_age_ff    <= rd_age_in;
         chk_vld_ff   <= chk_vld_in;
         rec_ff       <= rec_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      chk_slot_ff <= chk_slot_in;
   end

   // Log memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (lg_we) begin
         log_mem[lg_waddr] <= lg_wdata;
      end
      if (lg_re) begin
         lg_rd_ff <= log_mem[lg_raddr];
      end
   end

   // Last result memory; entries not yet written read as success.
   always_ff @(posedge clock) begin
      if (ch_we) begin
         ch_mem[cur_idx] <= req_ff.result_code;
      end
      if (ch_re) begin
         ch_rd_ff <= ch_mem[ch_raddr];
      end
   end

   celog_active_count #(
      .CH_DEPTH (CH_DEPTH)
   ) u_count (
      .clock  (clock),
      .reset  (reset),
      .start  (cnt_start),
      .limit  (cnt_limit),
      .flags  (err_ff),
      .status (cnt_status)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

@@ rtl/celog_active_count.sv @@
`timescale 1ns / 1ps

module celog_active_count import celog_pkg::*; #(
   parameter int CH_DEPTH = CHANNELS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [6:0]          limit,
   input  logic [CH_DEPTH-1:0] flags,
   output cnt_status_type      status
);

   localparam int CW = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [6:0] idx_ff, idx_in;
   logic [6:0] acc_ff, acc_in;

   // Walk the error flags one channel per cycle below the limit.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = 7'd0;
         acc_in  = 7'd0;
      end else if (busy_ff) begin
         if (idx_ff < limit) begin
            acc_in = acc_ff + 7'(flags[idx_ff[CW-1:0]]);
            idx_in = idx_ff + 7'd1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= 7'd0;
         acc_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
         acc_ff  <= acc_in;
      end
   end

   assign status.done  = done_ff;
   assign status.count = acc_ff;

endmodule
